FILE: hw/rtl/rx_frame_sync_checksum_defines.svh
// ---------------------------------------------------------------------------
// rx frame sync checksum assertion macros
// Property wrappers for the block that carries concurrent checks.
// ---------------------------------------------------------------------------
`ifndef RX_FRAME_SYNC_CHECKSUM_DEFINES_SVH
`define RX_FRAME_SYNC_CHECKSUM_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RFSC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rfsc check failed");

// next-cycle implication, sampled on clk, off during reset
`define RFSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rfsc check failed");

`endif

FILE: hw/rtl/rfsc_pkg.sv
// ---------------------------------------------------------------------------
// rfsc_pkg
// Shared constants and types of the receive frame synchronizer.
// ---------------------------------------------------------------------------
`default_nettype none

package rfsc_pkg;

	// frame geometry
	localparam int FRAME_BYTES = 12;
	localparam int CNT_W       = $clog2(FRAME_BYTES);
	localparam int POS_W       = 4;

	// frame terminator
	localparam logic [7:0] TERMINATOR = 8'h0D;

	// frame queue depth, a power of two
	localparam int FQ_DEPTH = 2;
	localparam int FQ_AW    = $clog2(FQ_DEPTH);

	typedef logic [7:0] data_byte_t;
	typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

	// front to queue: one checked frame
	typedef struct packed {
		logic   push;
		frame_t frame;
	} fq_wr_t;

	// queue to back: head frame and its status
	typedef struct packed {
		logic   empty;
		frame_t frame;
	} fq_rd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rx_frame_sync_checksum.sv
// A terminator word that completes a good frame writes it into the frame queue; an idle
// output side loads it from there and shows its first word. Throughput: one word per cycle in
// unless full; one frame word per cycle out while pop is high, FRAME_BYTES per frame.
// A two-entry frame queue lets a frame drain while the next one fills the window.
// Reset (arst_n low) empties the window, the frame queue and the output side at once.
// ---------------------------------------------------------------------------
// rx_frame_sync_checksum
// Frame synchronizer with terminator and additive checksum on a byte stream.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rx_frame_sync_checksum_defines.svh"

module rx_frame_sync_checksum (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [7:0]            rx_byte,
	input  wire logic                  pop,
	output logic                       empty,
	output logic [7:0]                 frame_byte,
	output logic [rfsc_pkg::POS_W-1:0] byte_position,
	output logic                       last_of_frame
);

	rfsc_pkg::fq_wr_t fq_wr;
	rfsc_pkg::fq_rd_t fq_rd;
	logic             fq_full;
	logic             rd_pop;
	logic             accept;
	logic             last_out;

	// input side stalls only on a full frame queue
	assign full   = fq_full;
	assign accept = push && !fq_full;

	rfsc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.fq_wr   (fq_wr)
	);

	rfsc_frame_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.fq_wr   (fq_wr),
		.rd_pop  (rd_pop),
		.fq_rd   (fq_rd),
		.fq_full (fq_full)
	);

	rfsc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.fq_rd         (fq_rd),
		.rd_pop        (rd_pop),
		.pop           (pop),
		.empty         (empty),
		.frame_byte    (frame_byte),
		.byte_position (byte_position),
		.last_of_frame (last_of_frame)
	);

	// last word of a frame leaves this cycle
	assign last_out = pop && !empty && last_of_frame;

	// a checked frame never meets a full queue
	`RFSC_ASSERT_SAME(a_no_push_when_full, fq_wr.push, !fq_full)
	// every frame handed out ends in the terminator
	`RFSC_ASSERT_SAME(a_last_is_term, !empty && last_of_frame, frame_byte == rfsc_pkg::TERMINATOR)
	// last word out with nothing queued leaves the output empty
	`RFSC_ASSERT_NEXT(a_drain_to_empty, last_out && fq_rd.empty, empty)
	// last word out with a frame queued starts the next frame at position zero
	`RFSC_ASSERT_NEXT(a_next_frame_start, last_out && !fq_rd.empty, !empty && byte_position == '0)

endmodule

`default_nettype wire

FILE: hw/rtl/rfsc_front.sv
// ---------------------------------------------------------------------------
// rfsc_front
// Sliding byte window with a running sum; checks terminator and checksum.
// ---------------------------------------------------------------------------
`default_nettype none

module rfsc_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire rfsc_pkg::data_byte_t rx_byte,
	output rfsc_pkg::fq_wr_t         fq_wr
);

	rfsc_pkg::frame_t                win_q;
	logic [rfsc_pkg::CNT_W-1:0]      fill_q;
	rfsc_pkg::data_byte_t            sum_q;
	rfsc_pkg::data_byte_t            newest;
	rfsc_pkg::data_byte_t            head_sum;
	logic                            completes;
	logic                            frame_ok;

	// newest stored byte sits at the top of the shift line
	assign newest    = win_q[rfsc_pkg::FRAME_BYTES-1];
	assign completes = (fill_q == rfsc_pkg::CNT_W'(rfsc_pkg::FRAME_BYTES - 1));
	// sum of all but the checksum byte
	assign head_sum  = sum_q - newest;
	assign frame_ok  = (rx_byte == rfsc_pkg::TERMINATOR) && (head_sum == newest);

	// frame as seen once this word is in: stored words shifted, new word on top
	always_comb begin
		for (int i = 0; i < rfsc_pkg::FRAME_BYTES - 1; i++) begin
			fq_wr.frame[i] = win_q[i+1];
		end
		fq_wr.frame[rfsc_pkg::FRAME_BYTES-1] = rx_byte;
		fq_wr.push = accept && completes && frame_ok;
	end

	// fill count and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sum_q  <= '0;
		end else if (accept) begin
			if (!completes) begin
				fill_q <= fill_q + rfsc_pkg::CNT_W'(1);
				sum_q  <= sum_q + rx_byte;
			end else if (frame_ok) begin
				fill_q <= '0;
				sum_q  <= '0;
			end else begin
				// oldest word slides out of the window
				sum_q  <= sum_q + rx_byte - win_q[1];
			end
		end
	end

	// window shift line
	always_ff @(posedge clk) begin
		if (accept) begin
			win_q <= fq_wr.frame;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/rfsc_frame_fifo.sv
// ---------------------------------------------------------------------------
// rfsc_frame_fifo
// Short queue of whole checked frames between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module rfsc_frame_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rfsc_pkg::fq_wr_t fq_wr,
	input  wire logic             rd_pop,
	output rfsc_pkg::fq_rd_t      fq_rd,
	output logic                  fq_full
);

	rfsc_pkg::frame_t           mem_q [rfsc_pkg::FQ_DEPTH];
	logic [rfsc_pkg::FQ_AW-1:0] wr_ptr_q;
	logic [rfsc_pkg::FQ_AW-1:0] rd_ptr_q;
	logic [rfsc_pkg::FQ_AW:0]   count_q;
	logic                       do_wr;
	logic                       do_rd;

	assign fq_full     = (count_q == (rfsc_pkg::FQ_AW+1)'(rfsc_pkg::FQ_DEPTH));
	assign fq_rd.empty = (count_q == '0);
	assign fq_rd.frame = mem_q[rd_ptr_q];
	assign do_wr       = fq_wr.push && !fq_full;
	assign do_rd       = rd_pop && !fq_rd.empty;

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + rfsc_pkg::FQ_AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + rfsc_pkg::FQ_AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (rfsc_pkg::FQ_AW+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (rfsc_pkg::FQ_AW+1)'(1);
			end
		end
	end

	// frame storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= fq_wr.frame;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/rfsc_back.sv
// ---------------------------------------------------------------------------
// rfsc_back
// Frame serializer: loads a frame and hands it out one word per pop.
// ---------------------------------------------------------------------------
`default_nettype none

module rfsc_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rfsc_pkg::fq_rd_t     fq_rd,
	output logic                      rd_pop,
	input  wire logic                 pop,
	output logic                      empty,
	output rfsc_pkg::data_byte_t      frame_byte,
	output logic [rfsc_pkg::POS_W-1:0] byte_position,
	output logic                      last_of_frame
);

	rfsc_pkg::frame_t           shreg_q;
	logic [rfsc_pkg::CNT_W-1:0] idx_q;
	logic                       busy_q;
	logic                       take;
	logic                       load;

	assign empty         = !busy_q;
	assign frame_byte    = shreg_q[0];
	assign byte_position = rfsc_pkg::POS_W'(idx_q);
	assign last_of_frame = (idx_q == rfsc_pkg::CNT_W'(rfsc_pkg::FRAME_BYTES - 1));
	assign take          = pop && busy_q;
	// next frame comes in when idle or as the last word leaves
	assign load          = !fq_rd.empty && (!busy_q || (take && last_of_frame));
	assign rd_pop        = load;

	// word index and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			if (last_of_frame) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + rfsc_pkg::CNT_W'(1);
			end
		end
	end

	// output shift line, oldest word at the bottom
	always_ff @(posedge clk) begin
		if (load) begin
			shreg_q <= fq_rd.frame;
		end else if (take) begin
			for (int i = 0; i < rfsc_pkg::FRAME_BYTES - 1; i++) begin
				shreg_q[i] <= shreg_q[i+1];
			end
		end
	end

endmodule

`default_nettype wire
